>>> rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg : shared types and constants of the LRU page replacement core
// Request and response payloads, frame store geometry and counter limits.
// ----------------------------------------------------------------------------
package lru_pkg;

    // Built frame count and stored page width
    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    // Fixed widths of the request and response fields
    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 3;
    localparam int COUNT_W       = 32;
    localparam int CFG_W         = 4;

    // Frame addressing: index into the store, and a count that can hold MAX_FRAMES
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    // One store entry: page number above last-use time
    localparam int ENTRY_W = PAGE_BITS + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Frame count after reset: 8, or MAX_FRAMES if that is smaller
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'((MAX_FRAMES < 8) ? MAX_FRAMES : 8);

    typedef struct packed {
        logic [PAGE_NUMBER_W-1:0] page_number;
        logic                     last_request;
    } lru_req_t;

    typedef struct packed {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     evicted_valid;
        logic [PAGE_NUMBER_W-1:0] evicted_page;
        logic [COUNT_W-1:0]       fault_count;
    } lru_rsp_t;

endpackage

>>> rtl/lru_ram.sv
// ----------------------------------------------------------------------------
// lru_ram : generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_core : LRU page replacement over a set of frames
// Fully associative frame store with last-use stamps, held in a RAM.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive req and pulse start; the request is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   response has been produced.
//   Response channel: rsp is valid for exactly the one cycle in which done is
//   high. The receiver cannot stall; it must take the response in that cycle.
//   Configuration: cfg_we with cfg_wdata writes frames_in_use (active frame
//   count, 0 acts as 1, above MAX_FRAMES acts as MAX_FRAMES). Write only while
//   busy is low and no response is pending.
//   Sequence: requests are handled one at a time: after the accept edge the
//   scan reads the active frames, the update state writes back, and done
//   rises after the update state; a new request may be given in the done
//   cycle. The scan is set by the single RAM read port: it reads one frame
//   per cycle and compares it in the next cycle, then the update state
//   writes the chosen frame back.
//   Reset: valid bits, request time, fault count and control are cleared at
//   once, the frame count returns to its reset value; the RAM needs no clear.
//   A request flagged last_request clears valid bits and counters after its
//   response.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
    import lru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lru_req_t         req,
    output logic             busy,
    output logic             done,
    output lru_rsp_t         rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       frames_in_use_reg;
    logic [MAX_FRAMES-1:0]  valid_reg;
    logic [COUNT_W-1:0]     time_reg;
    logic [COUNT_W-1:0]     faults_reg;

    // Request held for the whole scan
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   last_reg;
    logic [CNT_W-1:0]       n_reg;

    // Scan pipeline: read issue index and compare stage
    logic [CNT_W-1:0]       rd_idx_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;

    // Scan results
    logic                   hit_found_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic                   empty_found_reg;
    logic [IDX_W-1:0]       empty_idx_reg;
    logic                   min_found_reg;
    logic [IDX_W-1:0]       min_idx_reg;
    logic [COUNT_W-1:0]     min_use_reg;
    logic [PAGE_BITS-1:0]   min_page_reg;

    logic                   done_reg;
    lru_rsp_t               rsp_reg;

    // RAM ports
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [CNT_W-1:0]       n_next;
    logic                   issue;
    logic [PAGE_BITS-1:0]   rd_page;
    logic [COUNT_W-1:0]     rd_use;
    logic                   rd_valid;
    logic                   last_cmp;
    logic [IDX_W-1:0]       slot;
    logic                   evict;
    logic [COUNT_W-1:0]     faults_next;

    lru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Clamp the configured frame count to 1 .. MAX_FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            n_next = CNT_W'(1);
        end
        else if (7'(frames_in_use_reg) > 7'(MAX_FRAMES))
        begin
            n_next = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_next = CNT_W'(frames_in_use_reg);
        end
    end

    // Issue one read per cycle while frames remain; data lands in the next cycle
    assign issue    = (state_reg == S_SCAN) && (rd_idx_reg < n_reg);
    assign ram_re   = issue;
    assign rd_page  = ram_rdata[ENTRY_W-1:COUNT_W];
    assign rd_use   = ram_rdata[COUNT_W-1:0];
    assign rd_valid = valid_reg[cmp_idx_reg];
    assign last_cmp = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == n_reg - CNT_W'(1));

    // Pick the frame to take: the hit, else first empty, else the oldest
    assign evict = !hit_found_reg && !empty_found_reg;
    always_comb
    begin
        if (hit_found_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_idx_reg;
        end
        else
        begin
            slot = min_idx_reg;
        end
    end

    assign faults_next = (!hit_found_reg && faults_reg != COUNT_MAX)
                         ? faults_reg + COUNT_W'(1) : faults_reg;

    // The write-back lands before the next request can issue a read,
    // so reads and writes of one entry never overlap
    assign ram_we    = (state_reg == S_UPDATE);
    assign ram_waddr = slot;
    assign ram_wdata = {page_reg, time_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            frames_in_use_reg <= CFG_RESET;
            valid_reg         <= '0;
            time_reg          <= '0;
            faults_reg        <= '0;
            done_reg          <= 1'b0;
            cmp_vld_reg       <= 1'b0;
        end
        else
        begin
            // raise done in the cycle after the update state
            done_reg <= (state_reg == S_UPDATE);
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        page_reg        <= req.page_number[PAGE_BITS-1:0];
                        last_reg        <= req.last_request;
                        n_reg           <= n_next;
                        rd_idx_reg      <= '0;
                        cmp_vld_reg     <= 1'b0;
                        hit_found_reg   <= 1'b0;
                        empty_found_reg <= 1'b0;
                        min_found_reg   <= 1'b0;
                        state_reg       <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // advance the read pointer; no read is left once the last
                    // frame is in the compare stage
                    cmp_vld_reg <= issue;
                    cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    // compare the frame read last cycle; keep the first of each kind
                    if (cmp_vld_reg)
                    begin
                        if (rd_valid && rd_page == page_reg && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= cmp_idx_reg;
                        end
                        if (!rd_valid && !empty_found_reg)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_idx_reg   <= cmp_idx_reg;
                        end
                        if (rd_valid && (!min_found_reg || rd_use < min_use_reg))
                        begin
                            min_found_reg <= 1'b1;
                            min_idx_reg   <= cmp_idx_reg;
                            min_use_reg   <= rd_use;
                            min_page_reg  <= rd_page;
                        end
                    end
                    if (last_cmp)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    rsp_reg.hit           <= hit_found_reg;
                    rsp_reg.frame_index   <= FRAME_INDEX_W'(slot);
                    rsp_reg.evicted_valid <= evict;
                    rsp_reg.evicted_page  <= evict ? PAGE_NUMBER_W'(min_page_reg) : '0;
                    rsp_reg.fault_count   <= faults_next;
                    state_reg             <= S_IDLE;
                    if (last_reg)
                    begin
                        // drop the whole store after the final request
                        valid_reg  <= '0;
                        time_reg   <= '0;
                        faults_reg <= '0;
                    end
                    else
                    begin
                        valid_reg[slot] <= 1'b1;
                        faults_reg      <= faults_next;
                        if (time_reg != COUNT_MAX)
                        begin
                            time_reg <= time_reg + COUNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
